### design/dsdt_pkg.sv
// shared types and constants for the disk seek distance timer
package dsdt_pkg;

	localparam int BLK_W  = 32;
	localparam int CYL_W  = 16;
	localparam int DIST_W = 4;
	localparam int TIME_W = 20;
	localparam int STEP_W = 16;
	localparam int IDX_W  = 3;

	localparam logic [DIST_W-1:0] DIST_LIMIT = 4'd10;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_MOUNTED  = 3'd0;
	localparam logic [IDX_W-1:0] REG_TOTAL    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SPT      = 3'd2;
	localparam logic [IDX_W-1:0] REG_SURFACES = 3'd3;
	localparam logic [IDX_W-1:0] REG_CYLS     = 3'd4;
	localparam logic [IDX_W-1:0] REG_SEC_TIME = 3'd5;
	localparam logic [IDX_W-1:0] REG_TRK_TIME = 3'd6;

	// sequencing for a cylinder unit
	typedef struct packed {
		logic load;
		logic step;
	} cyl_ctrl_t;

endpackage

### design/dsdt_cyl_unit.sv
// bit-serial cylinder unit: block / (spt * surfaces) mod cylinders, one bit per stepped cycle
module dsdt_cyl_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dsdt_pkg::cyl_ctrl_t              ctrl,
	input  logic [dsdt_pkg::BLK_W-1:0]       dividend,
	input  logic [dsdt_pkg::CYL_W-1:0]       divisor,
	input  logic [dsdt_pkg::CYL_W-1:0]       modulus,
	output logic [dsdt_pkg::CYL_W-1:0]       cyl
);

	logic [dsdt_pkg::BLK_W-1:0] dvd_q;
	logic [dsdt_pkg::CYL_W-1:0] rem_q;
	logic [dsdt_pkg::CYL_W-1:0] mod_q;
	logic [dsdt_pkg::CYL_W:0]   trial;
	logic [dsdt_pkg::CYL_W:0]   macc;
	logic                       qbit;
	logic                       mbit;
	logic [dsdt_pkg::CYL_W-1:0] rem_nx;
	logic [dsdt_pkg::CYL_W-1:0] mod_nx;

	// restoring division step, quotient bit comes out msb first
	always_comb begin
		trial  = {rem_q, dvd_q[dsdt_pkg::BLK_W-1]};
		qbit   = trial >= {1'b0, divisor};
		rem_nx = qbit ? dsdt_pkg::CYL_W'(trial - {1'b0, divisor}) : trial[dsdt_pkg::CYL_W-1:0];
		// fold the quotient bit into the running modulo, stays below twice the modulus
		macc   = {mod_q, qbit};
		mbit   = macc >= {1'b0, modulus};
		mod_nx = mbit ? dsdt_pkg::CYL_W'(macc - {1'b0, modulus}) : macc[dsdt_pkg::CYL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q <= '0;
			rem_q <= '0;
			mod_q <= '0;
		end else if (ctrl.load) begin
			dvd_q <= dividend;
			rem_q <= '0;
			mod_q <= '0;
		end else if (ctrl.step) begin
			dvd_q <= {dvd_q[dsdt_pkg::BLK_W-2:0], 1'b0};
			rem_q <= rem_nx;
			mod_q <= mod_nx;
		end
	end

	assign cyl = mod_q;

endmodule

### design/disk_seek_distance_timer_top.sv
// top level of the disk seek distance timer
// usage
//   s_* carries one request item: func (0 access and move head, 1 estimate) and a block
//   number. m_* returns one result item per request: ok, cylinder distance (clamped to
//   10) and access time. the cfg channel writes the seven disk geometry and timing
//   registers by index; cfg_ready is always high and indexes beyond 6 are dropped.
//   registers are to be written only while the block is idle; the block does not enforce it.
// timing
//   the cylinders of the requested block and of the block under the head are worked
//   out by two bit-serial divide/modulo units running side by side, one quotient bit per
//   cycle over the 32 bits of the block number. the accept edge loads both units; after
//   the serial steps the distance is registered, then the access time is written to
//   the output register. a new item is taken in the cycle after the previous result
//   has been loaded into the output register; no item is taken while one is in work.
// reset
//   arst_n clears the head position to block 0, loads the register defaults (not
//   mounted, one sector, one of each geometry count, zero times) and empties the output.
// stalls
//   a result waits in the output register while m_tready is low; the next item is still
//   accepted and worked on, and only its final write waits for the output to drain.
module disk_seek_distance_timer_top (
	input  logic        clk,
	input  logic        arst_n,
	// request items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] func, [32:1] block_number, [39:33] zero
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [0] ok, [4:1] cylinder_distance, [24:5] access_time, [31:25] zero
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DIST = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [4:0] cnt_q;

	// configuration registers
	logic                         mounted_q;
	logic [dsdt_pkg::BLK_W-1:0]   total_q;
	logic [7:0]                   spt_q;
	logic [7:0]                   surf_q;
	logic [dsdt_pkg::CYL_W-1:0]   cyls_q;
	logic [dsdt_pkg::STEP_W-1:0]  sec_time_q;
	logic [dsdt_pkg::STEP_W-1:0]  trk_time_q;

	// head position
	logic [dsdt_pkg::BLK_W-1:0]   cur_blk_q;

	// per item registers
	logic                         func_q;
	logic                         ok_q;
	logic [dsdt_pkg::BLK_W-1:0]   blk_q;
	logic [dsdt_pkg::CYL_W-1:0]   div_q;
	logic [dsdt_pkg::CYL_W-1:0]   mod_q;
	logic [dsdt_pkg::DIST_W-1:0]  dist_q;

	// output register
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	logic                         s_fire;
	logic                         emit_fire;
	logic                         keep;
	logic                         ok_in;
	logic [dsdt_pkg::BLK_W-1:0]   in_blk;
	logic [7:0]                   spt_nz;
	logic [7:0]                   surf_nz;
	logic [dsdt_pkg::CYL_W-1:0]   div_in;
	logic [dsdt_pkg::CYL_W-1:0]   mod_in;
	dsdt_pkg::cyl_ctrl_t          unit_ctrl;
	logic [dsdt_pkg::CYL_W-1:0]   cyl_req;
	logic [dsdt_pkg::CYL_W-1:0]   cyl_cur;
	logic [dsdt_pkg::CYL_W-1:0]   diff;
	logic [dsdt_pkg::DIST_W-1:0]  dist_nx;
	logic [dsdt_pkg::TIME_W-1:0]  time_nx;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign in_blk    = s_tdata[32:1];
	assign ok_in     = mounted_q && (in_blk < total_q);

	// a zero geometry count acts as one; floor(floor(b/x)/y) == floor(b/(x*y))
	assign spt_nz  = (spt_q == 8'd0) ? 8'd1 : spt_q;
	assign surf_nz = (surf_q == 8'd0) ? 8'd1 : surf_q;
	assign div_in  = dsdt_pkg::CYL_W'({8'd0, spt_nz} * {8'd0, surf_nz});
	assign mod_in  = (cyls_q == '0) ? dsdt_pkg::CYL_W'(1) : cyls_q;

	assign unit_ctrl.load = s_fire;
	assign unit_ctrl.step = (state_q == ST_RUN);

	// a failed access reports zero distance and zero time
	assign keep      = func_q || ok_q;
	assign emit_fire = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	// cylinder of the requested block
	dsdt_cyl_unit u_cyl_req (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (unit_ctrl),
		.dividend (in_blk),
		.divisor  (div_q),
		.modulus  (mod_q),
		.cyl      (cyl_req)
	);

	// cylinder of the block under the head, recomputed since geometry may have changed
	dsdt_cyl_unit u_cyl_cur (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (unit_ctrl),
		.dividend (cur_blk_q),
		.divisor  (div_q),
		.modulus  (mod_q),
		.cyl      (cyl_cur)
	);

	// absolute distance, clamped
	always_comb begin
		diff    = (cyl_cur > cyl_req) ? (cyl_cur - cyl_req) : (cyl_req - cyl_cur);
		dist_nx = (diff > dsdt_pkg::CYL_W'(dsdt_pkg::DIST_LIMIT)) ? dsdt_pkg::DIST_LIMIT :
			diff[dsdt_pkg::DIST_W-1:0];
	end

	// access time from the registered distance: 4 x 16 product, sector time at zero distance
	always_comb begin
		if (!keep) begin
			time_nx = '0;
		end else if (dist_q == '0) begin
			time_nx = dsdt_pkg::TIME_W'(sec_time_q);
		end else begin
			time_nx = dsdt_pkg::TIME_W'({16'd0, dist_q} * {4'd0, trk_time_q});
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mounted_q  <= 1'b0;
			total_q    <= 32'd1;
			spt_q      <= 8'd1;
			surf_q     <= 8'd1;
			cyls_q     <= 16'd1;
			sec_time_q <= '0;
			trk_time_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dsdt_pkg::REG_MOUNTED:  mounted_q  <= cfg_data[0];
				dsdt_pkg::REG_TOTAL:    total_q    <= cfg_data;
				dsdt_pkg::REG_SPT:      spt_q      <= cfg_data[7:0];
				dsdt_pkg::REG_SURFACES: surf_q     <= cfg_data[7:0];
				dsdt_pkg::REG_CYLS:     cyls_q     <= cfg_data[15:0];
				dsdt_pkg::REG_SEC_TIME: sec_time_q <= cfg_data[15:0];
				dsdt_pkg::REG_TRK_TIME: trk_time_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_DIST;
					end
				end
				ST_DIST: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per item capture
	always_ff @(posedge clk) begin
		if (s_fire) begin
			func_q <= s_tdata[0];
			ok_q   <= ok_in;
			blk_q  <= in_blk;
			div_q  <= div_in;
			mod_q  <= mod_in;
		end
		if (state_q == ST_DIST) begin
			dist_q <= keep ? dist_nx : '0;
		end
	end

	// head moves only on a successful access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_blk_q <= '0;
		end else if (emit_fire && !func_q && ok_q) begin
			cur_blk_q <= blk_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= {7'd0, time_nx, dist_q, ok_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// no second item is taken while one is being worked on
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("item accepted while the previous one is still in the serial units");

	// the head position changes only at the final write of a successful access
	a_head_move: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_blk_q != $past(cur_blk_q)) |->
		($past(state_q == ST_EMIT) && $past(emit_fire) && $past(!func_q) && $past(ok_q)))
		else $error("head moved outside a successful access");

	// reported distance never exceeds the clamp
	a_dist_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:1] <= dsdt_pkg::DIST_LIMIT))
		else $error("cylinder distance above the clamp");

	// a failed access reports no time
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && !func_q && !ok_q) |=> (m_tdata[24:1] == 24'd0))
		else $error("failed access reports a nonzero distance or time");

endmodule
